// ===== hdl/tpc_pkg.sv =====
`default_nettype none

package tpc_pkg;

   localparam int COORD_BITS      = 16;
   localparam int MAG_BITS        = COORD_BITS;
   localparam int SQ_BITS         = 2 * MAG_BITS;
   localparam int RAD_BITS        = SQ_BITS + 1;
   localparam int ROOT_BITS       = (RAD_BITS + 1) / 2;
   localparam int RAD_PAD_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS        = ROOT_BITS + 2;
   localparam int STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES     = (ROOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int SIDES           = 3;
   localparam int PERIM_BITS      = 20;
   localparam int LEN_SUM_BITS    = ROOT_BITS + 2;
   localparam int SUM_BITS        = (LEN_SUM_BITS > PERIM_BITS) ? LEN_SUM_BITS : PERIM_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [MAG_BITS-1:0]          mag_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [RAD_BITS-1:0]          rad_type;
   typedef logic [RAD_PAD_BITS-1:0]      rad_pad_type;
   typedef logic [REM_BITS-1:0]          rem_type;
   typedef logic [ROOT_BITS-1:0]         root_type;
   typedef logic [ROOT_BITS:0]           pair_sum_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [PERIM_BITS-1:0]        perim_type;

   localparam perim_type PERIM_MAX   = '1;
   localparam sum_type   PERIM_LIMIT = sum_type'(PERIM_MAX);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_COINCIDE = 2'd1,
      ST_NOTRI    = 2'd2
   } status_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by_coord;
      coord_type cx;
      coord_type cy;
   } req_type;

   typedef struct packed {
      perim_type  perimeter;
      status_type status;
   } rsp_type;

   // control that rides alongside each request through the root pipeline
   typedef struct packed {
      logic valid;
      logic coin;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hdl/tpc_sqrt.sv =====
`default_nettype none

module tpc_sqrt (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire tpc_pkg::ctl_type  in_ctl,
   input  wire tpc_pkg::rad_type  in_rad [tpc_pkg::SIDES],
   output tpc_pkg::ctl_type       out_ctl,
   output tpc_pkg::root_type      out_root [tpc_pkg::SIDES]
);

   tpc_pkg::ctl_type     ctl_ff  [tpc_pkg::SQRT_STAGES];
   tpc_pkg::ctl_type     ctl_in  [tpc_pkg::SQRT_STAGES];
   tpc_pkg::rad_pad_type rad_ff  [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];
   tpc_pkg::rad_pad_type rad_in  [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];
   tpc_pkg::rem_type     rem_ff  [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];
   tpc_pkg::rem_type     rem_in  [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];
   tpc_pkg::root_type    root_ff [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];
   tpc_pkg::root_type    root_in [tpc_pkg::SQRT_STAGES][tpc_pkg::SIDES];

   // stages retire up to STEPS_PER_STAGE root bits, a radicand pair per step
   always_comb begin
      tpc_pkg::rad_pad_type rad_w;
      tpc_pkg::rem_type     rem_w;
      tpc_pkg::root_type    root_w;
      tpc_pkg::rem_type     trial;
      for (int k = 0; k < tpc_pkg::SQRT_STAGES; k++) begin
         if (k == 0) begin
            ctl_in[k] = in_ctl;
         end else begin
            ctl_in[k] = ctl_ff[k-1];
         end
         for (int i = 0; i < tpc_pkg::SIDES; i++) begin
            if (k == 0) begin
               rad_w  = tpc_pkg::rad_pad_type'(in_rad[i]);
               rem_w  = '0;
               root_w = '0;
            end else begin
               rad_w  = rad_ff[k-1][i];
               rem_w  = rem_ff[k-1][i];
               root_w = root_ff[k-1][i];
            end
            for (int j = 0; j < tpc_pkg::STEPS_PER_STAGE; j++) begin
               if (k * tpc_pkg::STEPS_PER_STAGE + j < tpc_pkg::ROOT_BITS) begin
                  rem_w = {rem_w[tpc_pkg::REM_BITS-3:0],
                           rad_w[tpc_pkg::RAD_PAD_BITS-1 -: 2]};
                  rad_w = rad_w << 2;
                  trial = {root_w, 2'b01};
                  if (rem_w >= trial) begin
                     rem_w  = rem_w - trial;
                     root_w = {root_w[tpc_pkg::ROOT_BITS-2:0], 1'b1};
                  end else begin
                     root_w = {root_w[tpc_pkg::ROOT_BITS-2:0], 1'b0};
                  end
               end
            end
            rad_in[k][i]  = rad_w;
            rem_in[k][i]  = rem_w;
            root_in[k][i] = root_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < tpc_pkg::SQRT_STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_ctl  = ctl_ff[tpc_pkg::SQRT_STAGES-1];
   assign out_root = root_ff[tpc_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/triangle_perimeter_check.sv =====
// Triangle perimeter check.
// A request on req_data carries three vertices as signed coordinates with 4
// fraction bits. Each request yields exactly one response on rsp_data: the
// perimeter (sum of the floored side lengths, 4 fraction bits) and a status
// of ok, coincident vertices, or failed triangle inequality. The perimeter
// is zero whenever the status is not ok.
// Both channels use valid/ready. The pipeline registers are input,
// difference, square, sum, nine square-root stages (two root bits
// each, one in the last), the inequality check and the response
// register. Throughput is one request per cycle when nothing stalls;
// the square root is fully pipelined.
// req_ready is high whenever the response register is empty or being read.
// When the receiver holds rsp_ready low with a response waiting, the whole
// pipeline freezes and req_ready drops; no request is lost or repeated.
// Synchronous reset empties the pipeline; no response is pending after it.
`default_nettype none

module triangle_perimeter_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tpc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tpc_pkg::rsp_type      rsp_data
);

   logic                  en;
   logic                  v1_ff;
   tpc_pkg::req_type      req_ff;
   tpc_pkg::ctl_type      ctl2_ff, ctl2_in;
   tpc_pkg::mag_type      mag_ff [2*tpc_pkg::SIDES];
   tpc_pkg::mag_type      mag_in [2*tpc_pkg::SIDES];
   tpc_pkg::ctl_type      ctl3_ff;
   tpc_pkg::sq_type       sq_ff  [2*tpc_pkg::SIDES];
   tpc_pkg::sq_type       sq_in  [2*tpc_pkg::SIDES];
   tpc_pkg::ctl_type      ctl4_ff;
   tpc_pkg::rad_type      rad_ff [tpc_pkg::SIDES];
   tpc_pkg::rad_type      rad_in [tpc_pkg::SIDES];
   tpc_pkg::ctl_type      root_ctl;
   tpc_pkg::root_type     root   [tpc_pkg::SIDES];
   logic                  v5_ff;
   tpc_pkg::status_type   status5_ff, status5_in;
   tpc_pkg::sum_type      total5_ff, total5_in;
   logic                  rsp_valid_ff;
   tpc_pkg::rsp_type      rsp_ff, rsp_in;

   function automatic tpc_pkg::mag_type abs_diff(tpc_pkg::coord_type p,
                                                 tpc_pkg::coord_type q);
      logic signed [tpc_pkg::COORD_BITS:0] d;
      d = {p[tpc_pkg::COORD_BITS-1], p} - {q[tpc_pkg::COORD_BITS-1], q};
      if (d[tpc_pkg::COORD_BITS]) begin
         return tpc_pkg::mag_type'(-d);
      end
      return tpc_pkg::mag_type'(d);
   endfunction

   // the whole pipeline advances unless a response is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 2: coordinate differences and coincidence
   always_comb begin
      mag_in[0] = abs_diff(req_ff.bx, req_ff.ax);
      mag_in[1] = abs_diff(req_ff.by_coord, req_ff.ay);
      mag_in[2] = abs_diff(req_ff.cx, req_ff.ax);
      mag_in[3] = abs_diff(req_ff.cy, req_ff.ay);
      mag_in[4] = abs_diff(req_ff.cx, req_ff.bx);
      mag_in[5] = abs_diff(req_ff.cy, req_ff.by_coord);
      ctl2_in.valid = v1_ff;
      ctl2_in.coin  = (req_ff.ax == req_ff.bx && req_ff.ay == req_ff.by_coord) ||
                      (req_ff.ax == req_ff.cx && req_ff.ay == req_ff.cy) ||
                      (req_ff.bx == req_ff.cx && req_ff.by_coord == req_ff.cy);
   end

   // stage 3: squares
   always_comb begin
      for (int i = 0; i < 2*tpc_pkg::SIDES; i++) begin
         sq_in[i] = tpc_pkg::sq_type'(mag_ff[i]) * tpc_pkg::sq_type'(mag_ff[i]);
      end
   end

   // stage 4: squared side lengths
   always_comb begin
      for (int s = 0; s < tpc_pkg::SIDES; s++) begin
         rad_in[s] = tpc_pkg::rad_type'(sq_ff[2*s]) + tpc_pkg::rad_type'(sq_ff[2*s+1]);
      end
   end

   tpc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (ctl4_ff),
      .in_rad   (rad_ff),
      .out_ctl  (root_ctl),
      .out_root (root)
   );

   // check stage: strict triangle inequality on the floored lengths
   always_comb begin
      tpc_pkg::pair_sum_type s01, s02, s12;
      logic                  tri_ok;
      s01 = tpc_pkg::pair_sum_type'(root[0]) + tpc_pkg::pair_sum_type'(root[1]);
      s02 = tpc_pkg::pair_sum_type'(root[0]) + tpc_pkg::pair_sum_type'(root[2]);
      s12 = tpc_pkg::pair_sum_type'(root[1]) + tpc_pkg::pair_sum_type'(root[2]);
      tri_ok = (s01 > tpc_pkg::pair_sum_type'(root[2])) &&
               (s02 > tpc_pkg::pair_sum_type'(root[1])) &&
               (s12 > tpc_pkg::pair_sum_type'(root[0]));
      total5_in = tpc_pkg::sum_type'(s01) + tpc_pkg::sum_type'(root[2]);
      if (root_ctl.coin) begin
         status5_in = tpc_pkg::ST_COINCIDE;
      end else if (tri_ok) begin
         status5_in = tpc_pkg::ST_OK;
      end else begin
         status5_in = tpc_pkg::ST_NOTRI;
      end
   end

   // response: saturate and drop the perimeter on a failed status
   always_comb begin
      rsp_in.status = status5_ff;
      if (status5_ff != tpc_pkg::ST_OK) begin
         rsp_in.perimeter = '0;
      end else if (total5_ff > tpc_pkg::PERIM_LIMIT) begin
         rsp_in.perimeter = tpc_pkg::PERIM_MAX;
      end else begin
         rsp_in.perimeter = total5_ff[tpc_pkg::PERIM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         ctl2_ff      <= '0;
         ctl3_ff      <= '0;
         ctl4_ff      <= '0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         ctl2_ff      <= ctl2_in;
         ctl3_ff      <= ctl2_ff;
         ctl4_ff      <= ctl3_ff;
         v5_ff        <= root_ctl.valid;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff     <= req_data;
         mag_ff     <= mag_in;
         sq_ff      <= sq_in;
         rad_ff     <= rad_in;
         status5_ff <= status5_in;
         total5_ff  <= total5_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response pending right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != tpc_pkg::ST_OK |-> rsp_ff.perimeter == '0)
      else $error("nonzero perimeter on a failed status");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == tpc_pkg::ST_OK |-> rsp_ff.perimeter != '0)
      else $error("zero perimeter on a valid triangle");

   a_check_fed: assert property (@(posedge clock) disable iff (reset)
      en && root_ctl.valid |=> v5_ff)
      else $error("root result dropped before the check stage");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_REQUESTS = 1840;
   localparam int PHASE_REQUESTS  = RANDOM_REQUESTS / 4;
   localparam int PRESSURE_AT     = 100;
   localparam int PRESSURE_CYCLES = 120;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 40;

   typedef struct {
      tpc_pkg::req_type req;
      bit               typed;
      tpc_pkg::rsp_type want;
   } row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tpc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tpc_pkg::rsp_type rsp_data;

   tpc_pkg::rsp_type pending_rsp[$];
   row_type          directed_rows[$];
   int               accepted_count = 0;
   int               mismatch_count = 0;
   int               status_seen[3] = '{0, 0, 0};
   int               hold_left = 0;
   bit               pressure_done = 0;

   triangle_perimeter_check uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both lightly
   function automatic int idle_phase(int count);
      int phase;
      if (count < directed_rows.size()) return 0;
      phase = (count - directed_rows.size()) / PHASE_REQUESTS;
      return (phase > 3) ? 3 : phase;
   endfunction

   function automatic logic [63:0] side_root(longint dx, longint dy);
      logic [65:0] ux, uy, radicand, rem, root, trial;
      ux = (dx < 0) ? 66'(-dx) : 66'(dx);
      uy = (dy < 0) ? 66'(-dy) : 66'(dy);
      radicand = ux * ux + uy * uy;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | 66'(radicand[2*i +: 2]);
         trial = (root << 2) | 66'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 66'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic tpc_pkg::rsp_type predict_perimeter(tpc_pkg::req_type r);
      longint x1, y1, x2, y2, x3, y3;
      logic [63:0] l1, l2, l3, total;
      tpc_pkg::rsp_type result;
      x1 = longint'($signed(r.ax));
      y1 = longint'($signed(r.ay));
      x2 = longint'($signed(r.bx));
      y2 = longint'($signed(r.by_coord));
      x3 = longint'($signed(r.cx));
      y3 = longint'($signed(r.cy));
      result.perimeter = '0;
      if ((x1 == x2 && y1 == y2) || (x1 == x3 && y1 == y3) || (x2 == x3 && y2 == y3)) begin
         result.status = tpc_pkg::ST_COINCIDE;
         return result;
      end
      l1 = side_root(x2 - x1, y2 - y1);
      l2 = side_root(x3 - x1, y3 - y1);
      l3 = side_root(x3 - x2, y3 - y2);
      if (!((l1 + l2 > l3) && (l1 + l3 > l2) && (l2 + l3 > l1))) begin
         result.status = tpc_pkg::ST_NOTRI;
         return result;
      end
      total = l1 + l2 + l3;
      result.perimeter = (total > 64'(tpc_pkg::PERIM_MAX)) ? tpc_pkg::PERIM_MAX :
                         tpc_pkg::perim_type'(total);
      result.status = tpc_pkg::ST_OK;
      return result;
   endfunction

   function automatic row_type make_row(int ax, int ay, int bx, int by, int cx, int cy,
                                        bit typed, int perim,
                                        tpc_pkg::status_type status);
      row_type row;
      row.req.ax = tpc_pkg::coord_type'(ax);
      row.req.ay = tpc_pkg::coord_type'(ay);
      row.req.bx = tpc_pkg::coord_type'(bx);
      row.req.by_coord = tpc_pkg::coord_type'(by);
      row.req.cx = tpc_pkg::coord_type'(cx);
      row.req.cy = tpc_pkg::coord_type'(cy);
      row.typed = typed;
      row.want.perimeter = tpc_pkg::perim_type'(perim);
      row.want.status = status;
      return row;
   endfunction

   // half full-range triangles, plus small, collinear and coincident shapes
   function automatic tpc_pkg::req_type random_triangle();
      tpc_pkg::req_type r;
      int mode, x0, y0, dx, dy, k1, k2;
      mode = $urandom_range(99);
      if (mode < 50) begin
         r = {$urandom, $urandom, $urandom};
      end else if (mode < 65) begin
         r.ax = tpc_pkg::coord_type'($urandom_range(127) - 64);
         r.ay = tpc_pkg::coord_type'($urandom_range(127) - 64);
         r.bx = tpc_pkg::coord_type'($urandom_range(127) - 64);
         r.by_coord = tpc_pkg::coord_type'($urandom_range(127) - 64);
         r.cx = tpc_pkg::coord_type'($urandom_range(127) - 64);
         r.cy = tpc_pkg::coord_type'($urandom_range(127) - 64);
      end else if (mode < 80) begin
         x0 = $urandom_range(16383) - 8192;
         y0 = $urandom_range(16383) - 8192;
         dx = $urandom_range(4000) - 2000;
         dy = $urandom_range(4000) - 2000;
         k1 = $urandom_range(3, 1);
         k2 = $urandom_range(6) - 3;
         r.ax = tpc_pkg::coord_type'(x0);
         r.ay = tpc_pkg::coord_type'(y0);
         r.bx = tpc_pkg::coord_type'(x0 + k1 * dx);
         r.by_coord = tpc_pkg::coord_type'(y0 + k1 * dy);
         r.cx = tpc_pkg::coord_type'(x0 + k2 * dx);
         r.cy = tpc_pkg::coord_type'(y0 + k2 * dy);
      end else begin
         r = {$urandom, $urandom, $urandom};
         case ($urandom_range(2))
            0: begin
               r.bx = r.ax;
               r.by_coord = r.ay;
            end
            1: begin
               r.cx = r.ax;
               r.cy = r.ay;
            end
            default: begin
               r.cx = r.bx;
               r.cy = r.by_coord;
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_request(input tpc_pkg::req_type r, input tpc_pkg::rsp_type want);
      int idle_pct;
      idle_pct = (idle_phase(accepted_count) == 1) ? 81 :
                 (idle_phase(accepted_count) == 3) ? 8 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_data <= {$urandom, $urandom, $urandom};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(want);
      accepted_count++;
      @(negedge clock);
   endtask

   // receiver: random stalls by phase, and one long hold to back up the pipeline
   initial begin
      int stall_pct;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            pressure_done = 1;
            hold_left = PRESSURE_CYCLES;
         end
         stall_pct = (idle_phase(accepted_count) == 2) ? 81 :
                     (idle_phase(accepted_count) == 3) ? 8 : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      tpc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_data.status <= tpc_pkg::ST_NOTRI) status_seen[rsp_data.status]++;
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected response perimeter=%0d status=%0d",
                                      rsp_data.perimeter, rsp_data.status));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.perimeter !== want.perimeter)
               report_mismatch($sformatf("perimeter %0d, expected %0d",
                                         rsp_data.perimeter, want.perimeter));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, want.status));
         end
      end
   end

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;

      directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1, 0, tpc_pkg::ST_COINCIDE));
      directed_rows.push_back(make_row(100, -200, 100, -200, 5, 5, 1, 0,
                                       tpc_pkg::ST_COINCIDE));
      directed_rows.push_back(make_row(-32768, 32767, 0, 0, -32768, 32767, 1, 0,
                                       tpc_pkg::ST_COINCIDE));
      directed_rows.push_back(make_row(1, 2, 32767, -32768, 32767, -32768, 1, 0,
                                       tpc_pkg::ST_COINCIDE));
      directed_rows.push_back(make_row(-32768, -32768, -32768, -32768, -32768, -32768,
                                       1, 0, tpc_pkg::ST_COINCIDE));
      directed_rows.push_back(make_row(0, 0, 16, 0, 32, 0, 1, 0, tpc_pkg::ST_NOTRI));
      directed_rows.push_back(make_row(0, 0, 1, 1, 2, 2, 1, 0, tpc_pkg::ST_NOTRI));
      directed_rows.push_back(make_row(0, 0, 48, 0, 0, 64, 1, 192, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(0, 0, 1, 0, 0, 1, 1, 3, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(-32768, -32768, 32767, 32767, -32768, 32767,
                                       0, 0, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(32767, -32768, -32768, 32767, 32767, 32767,
                                       0, 0, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(32767, 32767, -32768, -32768, 32767, -32768,
                                       0, 0, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(-32768, -32768, 0, 0, 32767, 32767, 0, 0,
                                       tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(-1, -1, -16, -1, -1, -16, 0, 0, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(0, 0, 1000, 1, 2000, 0, 0, 0, tpc_pkg::ST_OK));
      directed_rows.push_back(make_row(-32768, 0, 32767, 0, 0, 1, 0, 0, tpc_pkg::ST_OK));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed ?
                       directed_rows[i].want : predict_perimeter(directed_rows[i].req));

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         tpc_pkg::req_type r;
         r = random_triangle();
         offer_request(r, predict_perimeter(r));
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_rsp.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rsp.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

      $display("Sent %0d triangles over four idling phases and one long receiver hold.",
               accepted_count);
      $display("Responses: %0d ok, %0d coincident, %0d not a triangle; %0d mismatches.",
               status_seen[tpc_pkg::ST_OK], status_seen[tpc_pkg::ST_COINCIDE],
               status_seen[tpc_pkg::ST_NOTRI], mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tpc_pkg.sv
hdl/tpc_sqrt.sv
hdl/triangle_perimeter_check.sv
test/testbench.sv
